// ----- hw/rtl/i16p_pkg.sv -----
// shared types and constants of the intra 16x16 predictor
`timescale 1ns / 1ps
`default_nettype none

package i16p_pkg;

  // sample range used for clipping and mid-grey
  localparam int SAMPLE_BITS = 8;

  // fixed field widths
  localparam int PEL_W   = 8;
  localparam int POS_W   = 6;
  localparam int MODE_W  = 3;
  localparam int QUAD_W  = 6;
  localparam int QUADS   = 64;
  localparam int QUADS_PER_ROW = 4;

  // neighbour store layout
  localparam int STORE_W     = 8;
  localparam int STORE_DEPTH = 33;
  localparam int STORE_AW    = $clog2(STORE_DEPTH);
  localparam int TOP_BASE    = 1;
  localparam int LEFT_BASE   = 17;
  localparam int EDGE_LEN    = 16;

  // internal arithmetic widths
  localparam int HV_W  = SAMPLE_BITS + 8;
  localparam int BC_W  = SAMPLE_BITS + 4;
  localparam int PL_W  = SAMPLE_BITS + 10;
  localparam int SUM_W = SAMPLE_BITS + 6;

  localparam int CLIP_MAX      = (1 << SAMPLE_BITS) - 1;
  localparam int MID_GREY      = 1 << (SAMPLE_BITS - 1);
  localparam int DC_ROUND      = 8;
  localparam int DC_SHIFT_ONE  = 4;
  localparam int DC_SHIFT_BOTH = 5;
  localparam int PLANE_TAPS    = 8;
  localparam int PLANE_ROUND   = 16;
  localparam int PLANE_SHIFT   = 5;
  localparam int BC_ROUND      = 32;
  localparam int BC_SHIFT      = 6;

  // command queue
  localparam int QDEPTH = 2;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  typedef enum logic [1:0] {
    MODE_VERT  = 2'd0,
    MODE_HORZ  = 2'd1,
    MODE_DC    = 2'd2,
    MODE_PLANE = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_MISSING = 2'd1,
    ST_ILLEGAL = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    KIND_LOAD    = 2'd0,
    KIND_MISSING = 2'd1,
    KIND_ILLEGAL = 2'd2,
    KIND_PREDICT = 2'd3
  } kind_t;

  typedef struct packed {
    kind_t                kind;
    logic [STORE_AW-1:0]  pos;
    logic [STORE_W-1:0]   sample;
    mode_t                mode;
    logic                 left;
    logic                 top;
  } cmd_t;

  typedef struct packed {
    logic valid;
    cmd_t cmd;
  } cmdq_t;

endpackage

`default_nettype wire

// ----- hw/rtl/i16p_ram.sv -----
// generic single write port ram with registered read
`timescale 1ns / 1ps
`default_nettype none

module i16p_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 33
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

// ----- hw/rtl/i16p_front.sv -----
// front end: accepts transactions, classifies them and queues commands
`timescale 1ns / 1ps
`default_nettype none

module i16p_front import i16p_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire logic              in_func,
  input  wire logic [POS_W-1:0]  in_position,
  input  wire logic [STORE_W-1:0] in_sample,
  input  wire logic [MODE_W-1:0] in_mode,
  input  wire logic              in_left_available,
  input  wire logic              in_top_available,
  input  wire logic              in_corner_available,
  output cmdq_t                  q_head,
  input  wire logic              q_pop
);

  cmd_t              slot_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] cnt_r, cnt_nxt;
  cmd_t              cmd;
  logic              keep;
  logic              push;

  // classification
  always_comb begin
    cmd.pos    = in_position[STORE_AW-1:0];
    cmd.sample = in_sample;
    cmd.mode   = mode_t'(in_mode[1:0]);
    cmd.left   = in_left_available;
    cmd.top    = in_top_available;
    keep       = 1'b1;
    if (!in_func) begin
      cmd.kind = KIND_LOAD;
      // loads beyond the store are dropped here
      keep     = (in_position < POS_W'(STORE_DEPTH));
    end else if (in_mode[MODE_W-1]) begin
      cmd.kind = KIND_ILLEGAL;
    end else begin
      case (mode_t'(in_mode[1:0]))
        MODE_VERT: begin
          cmd.kind = in_top_available ? KIND_PREDICT : KIND_MISSING;
        end
        MODE_HORZ: begin
          cmd.kind = in_left_available ? KIND_PREDICT : KIND_MISSING;
        end
        MODE_PLANE: begin
          cmd.kind = (in_left_available && in_top_available && in_corner_available) ?
                     KIND_PREDICT : KIND_MISSING;
        end
        default: begin
          cmd.kind = KIND_PREDICT;
        end
      endcase
    end
  end

  assign in_stall = (cnt_r == QCNT_W'(QDEPTH));
  assign push     = in_valid && !in_stall && keep;

  always_comb begin
    wr_ptr_nxt = push  ? wr_ptr_r + QPTR_W'(1) : wr_ptr_r;
    rd_ptr_nxt = q_pop ? rd_ptr_r + QPTR_W'(1) : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push && !q_pop) begin
      cnt_nxt = cnt_r + QCNT_W'(1);
    end else if (!push && q_pop) begin
      cnt_nxt = cnt_r - QCNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= cmd;
    end
  end

  assign q_head.valid = (cnt_r != '0);
  assign q_head.cmd   = slot_r[rd_ptr_r];

endmodule

`default_nettype wire

// ----- hw/rtl/i16p_back.sv -----
// back end: store writes, neighbour gather, plane setup, quad generation and status results
`timescale 1ns / 1ps
`default_nettype none

module i16p_back import i16p_pkg::*; (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire cmdq_t               q_head,
  output logic                     q_pop,
  output logic                     ram_we,
  output logic [STORE_AW-1:0]      ram_waddr,
  output logic [STORE_W-1:0]       ram_wdata,
  output logic [STORE_AW-1:0]      ram_raddr,
  input  wire logic [STORE_W-1:0]  ram_rdata,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output logic [1:0]               out_status,
  output logic [QUAD_W-1:0]        out_quad_index,
  output logic [PEL_W-1:0]         out_pel0,
  output logic [PEL_W-1:0]         out_pel1,
  output logic [PEL_W-1:0]         out_pel2,
  output logic [PEL_W-1:0]         out_pel3,
  output logic                     out_last
);

  typedef enum logic [5:0] {
    S_IDLE    = 6'b000001,
    S_GATHER  = 6'b000010,
    S_CALC_HV = 6'b000100,
    S_CALC_BC = 6'b001000,
    S_CALC_Q  = 6'b010000,
    S_EMIT    = 6'b100000
  } state_t;

  state_t              state_r, state_nxt;
  logic [QUAD_W-1:0]   cnt_r, cnt_nxt;

  mode_t               mode_r;
  logic                use_left_r;
  logic                use_top_r;
  logic [STORE_W-1:0]  corner_r;
  logic [STORE_W-1:0]  top_r  [EDGE_LEN];
  logic [STORE_W-1:0]  left_r [EDGE_LEN];
  logic [SUM_W-1:0]    sum_r;
  logic [PEL_W-1:0]    dc_r, dc_nxt;
  logic signed [HV_W-1:0] h_r, v_r, h_sum, v_sum;
  logic signed [BC_W-1:0] b_r, c_r, b_nxt, c_nxt;
  logic signed [PL_W-1:0] q_r, rowbase_r, q0;
  logic signed [PL_W-1:0] bx, cx, ax;
  logic signed [HV_W+2:0] h5, v5;
  logic signed [PL_W-1:0] plane_v [QUADS_PER_ROW];
  logic [PEL_W-1:0]    quad_pel [QUADS_PER_ROW];

  status_t             st_r;
  logic [QUAD_W-1:0]   quad_r;
  logic [PEL_W-1:0]    pel_r [QUADS_PER_ROW];
  logic                last_r;
  logic                out_valid_r, out_valid_nxt;

  logic out_free, take, start_pred, emit_status, emit_quad, row_end;

  function automatic logic signed [HV_W-1:0] sx(input logic [STORE_W-1:0] p);
    sx = HV_W'(p);
  endfunction

  function automatic logic [PEL_W-1:0] clip_pel(input logic signed [PL_W-1:0] v);
    logic signed [PL_W-1:0] s;
    s = v >>> PLANE_SHIFT;
    if (s < 0) begin
      clip_pel = '0;
    end else if (s > CLIP_MAX) begin
      clip_pel = PEL_W'(CLIP_MAX);
    end else begin
      clip_pel = s[PEL_W-1:0];
    end
  endfunction

  // handshake with queue and output register
  assign out_free    = !out_valid_r || !out_stall;
  assign take        = (state_r == S_IDLE) && q_head.valid;
  assign start_pred  = take && (q_head.cmd.kind == KIND_PREDICT);
  assign emit_status = take && out_free &&
                       ((q_head.cmd.kind == KIND_MISSING) || (q_head.cmd.kind == KIND_ILLEGAL));
  assign q_pop       = take && ((q_head.cmd.kind == KIND_LOAD) ||
                                (q_head.cmd.kind == KIND_PREDICT) || out_free);
  assign emit_quad   = (state_r == S_EMIT) && out_free;
  assign row_end     = (cnt_r[1:0] == 2'(QUADS_PER_ROW - 1));

  assign ram_we    = take && (q_head.cmd.kind == KIND_LOAD);
  assign ram_waddr = q_head.cmd.pos;
  assign ram_wdata = q_head.cmd.sample;
  assign ram_raddr = (cnt_r < QUAD_W'(STORE_DEPTH)) ? cnt_r[STORE_AW-1:0] : '0;

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    case (state_r)
      S_IDLE: begin
        if (start_pred) begin
          state_nxt = S_GATHER;
          cnt_nxt   = '0;
        end
      end
      S_GATHER: begin
        cnt_nxt = cnt_r + QUAD_W'(1);
        if (cnt_r == QUAD_W'(STORE_DEPTH)) begin
          state_nxt = S_CALC_HV;
        end
      end
      S_CALC_HV: begin
        state_nxt = S_CALC_BC;
      end
      S_CALC_BC: begin
        state_nxt = S_CALC_Q;
      end
      S_CALC_Q: begin
        state_nxt = S_EMIT;
        cnt_nxt   = '0;
      end
      S_EMIT: begin
        if (emit_quad) begin
          cnt_nxt = cnt_r + QUAD_W'(1);
          if (cnt_r == QUAD_W'(QUADS - 1)) begin
            state_nxt = S_IDLE;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // plane gradients, one tap per neighbour pair
  always_comb begin
    h_sum = '0;
    v_sum = '0;
    for (int x = 0; x < PLANE_TAPS - 1; x++) begin
      h_sum = h_sum + HV_W'(x + 1) * (sx(top_r[PLANE_TAPS + x]) - sx(top_r[6 - x]));
      v_sum = v_sum + HV_W'(x + 1) * (sx(left_r[PLANE_TAPS + x]) - sx(left_r[6 - x]));
    end
    // outermost tap pairs with the corner
    h_sum = h_sum + HV_W'(PLANE_TAPS) * (sx(top_r[EDGE_LEN - 1]) - sx(corner_r));
    v_sum = v_sum + HV_W'(PLANE_TAPS) * (sx(left_r[EDGE_LEN - 1]) - sx(corner_r));
  end

  always_comb begin
    case ({use_left_r, use_top_r})
      2'b11:   dc_nxt = PEL_W'(sum_r >> DC_SHIFT_BOTH);
      2'b10,
      2'b01:   dc_nxt = PEL_W'(sum_r >> DC_SHIFT_ONE);
      default: dc_nxt = PEL_W'(MID_GREY);
    endcase
  end

  always_comb begin
    h5    = ((HV_W + 3)'(h_r) <<< 2) + (HV_W + 3)'(h_r) + (HV_W + 3)'(BC_ROUND);
    v5    = ((HV_W + 3)'(v_r) <<< 2) + (HV_W + 3)'(v_r) + (HV_W + 3)'(BC_ROUND);
    b_nxt = BC_W'(h5 >>> BC_SHIFT);
    c_nxt = BC_W'(v5 >>> BC_SHIFT);
    bx    = PL_W'(b_r);
    cx    = PL_W'(c_r);
    ax    = (PL_W'(top_r[EDGE_LEN - 1]) + PL_W'(left_r[EDGE_LEN - 1])) <<< 4;
    // value at x = 0, y = 0 before the final shift
    q0    = ax + PL_W'(PLANE_ROUND) - ((bx <<< 3) - bx) - ((cx <<< 3) - cx);
  end

  always_comb begin
    plane_v[0] = q_r;
    plane_v[1] = q_r + bx;
    plane_v[2] = q_r + (bx <<< 1);
    plane_v[3] = q_r + bx + (bx <<< 1);
    for (int i = 0; i < QUADS_PER_ROW; i++) begin
      case (mode_r)
        MODE_VERT:  quad_pel[i] = top_r[i];
        MODE_HORZ:  quad_pel[i] = left_r[0];
        MODE_DC:    quad_pel[i] = dc_r;
        MODE_PLANE: quad_pel[i] = clip_pel(plane_v[i]);
        default:    quad_pel[i] = '0;
      endcase
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r && out_stall;
    if (emit_status || emit_quad) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (start_pred) begin
      mode_r     <= q_head.cmd.mode;
      use_left_r <= q_head.cmd.left;
      use_top_r  <= q_head.cmd.top;
      sum_r      <= (q_head.cmd.left ? SUM_W'(DC_ROUND) : '0) +
                    (q_head.cmd.top  ? SUM_W'(DC_ROUND) : '0);
    end

    // store data is a registered read, so it belongs to the previous read address
    if (state_r == S_GATHER) begin
      case (cnt_r) inside
        QUAD_W'(TOP_BASE): begin
          corner_r <= ram_rdata;
        end
        [QUAD_W'(TOP_BASE + 1) : QUAD_W'(LEFT_BASE)]: begin
          for (int i = 0; i < EDGE_LEN - 1; i++) begin
            top_r[i] <= top_r[i + 1];
          end
          top_r[EDGE_LEN - 1] <= ram_rdata;
          if (use_top_r) begin
            sum_r <= sum_r + SUM_W'(ram_rdata);
          end
        end
        [QUAD_W'(LEFT_BASE + 1) : QUAD_W'(STORE_DEPTH)]: begin
          for (int i = 0; i < EDGE_LEN - 1; i++) begin
            left_r[i] <= left_r[i + 1];
          end
          left_r[EDGE_LEN - 1] <= ram_rdata;
          if (use_left_r) begin
            sum_r <= sum_r + SUM_W'(ram_rdata);
          end
        end
        default: begin
        end
      endcase
    end

    if (state_r == S_CALC_HV) begin
      h_r  <= h_sum;
      v_r  <= v_sum;
      dc_r <= dc_nxt;
    end

    if (state_r == S_CALC_BC) begin
      b_r <= b_nxt;
      c_r <= c_nxt;
    end

    if (state_r == S_CALC_Q) begin
      q_r       <= q0;
      rowbase_r <= q0;
    end

    if (emit_quad) begin
      // rotate the top row so the next four columns sit at the head
      for (int i = 0; i < EDGE_LEN; i++) begin
        top_r[i] <= top_r[(i + QUADS_PER_ROW) % EDGE_LEN];
      end
      if (row_end) begin
        for (int i = 0; i < EDGE_LEN - 1; i++) begin
          left_r[i] <= left_r[i + 1];
        end
        rowbase_r <= rowbase_r + cx;
        q_r       <= rowbase_r + cx;
      end else begin
        q_r <= q_r + (bx <<< 2);
      end
    end

    if (emit_status) begin
      st_r   <= (q_head.cmd.kind == KIND_ILLEGAL) ? ST_ILLEGAL : ST_MISSING;
      quad_r <= '0;
      for (int i = 0; i < QUADS_PER_ROW; i++) begin
        pel_r[i] <= '0;
      end
      last_r <= 1'b1;
    end else if (emit_quad) begin
      st_r   <= ST_OK;
      quad_r <= cnt_r;
      for (int i = 0; i < QUADS_PER_ROW; i++) begin
        pel_r[i] <= quad_pel[i];
      end
      last_r <= (cnt_r == QUAD_W'(QUADS - 1));
    end
  end

  assign out_valid      = out_valid_r;
  assign out_status     = st_r;
  assign out_quad_index = quad_r;
  assign out_pel0       = pel_r[0];
  assign out_pel1       = pel_r[1];
  assign out_pel2       = pel_r[2];
  assign out_pel3       = pel_r[3];
  assign out_last       = last_r;

endmodule

`default_nettype wire

// ----- hw/rtl/intra_16x16_prediction.sv -----
// intra 16x16 predictor: a load transaction takes one queue slot and is written to the store when the back end takes it
// a predict transaction gives its first quad after the 33-entry neighbour gather over the
// single store read port and the setup states S_CALC_HV, S_CALC_BC and S_CALC_Q,
// then one quad per cycle while out_stall is low, 64 quads per predicted block
// status results are registered into the output once the output register is free
// rst_n is synchronous, active low: clears queue, sequencer and output valid, not the store
`timescale 1ns / 1ps
`default_nettype none

module intra_16x16_prediction import i16p_pkg::*; (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic               in_func,
  input  wire logic [POS_W-1:0]   in_position,
  input  wire logic [STORE_W-1:0] in_sample,
  input  wire logic [MODE_W-1:0]  in_mode,
  input  wire logic               in_left_available,
  input  wire logic               in_top_available,
  input  wire logic               in_corner_available,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic [1:0]              out_status,
  output logic [QUAD_W-1:0]       out_quad_index,
  output logic [PEL_W-1:0]        out_pel0,
  output logic [PEL_W-1:0]        out_pel1,
  output logic [PEL_W-1:0]        out_pel2,
  output logic [PEL_W-1:0]        out_pel3,
  output logic                    out_last
);

  cmdq_t               q_head;
  logic                q_pop;
  logic                ram_we;
  logic [STORE_AW-1:0] ram_waddr, ram_raddr;
  logic [STORE_W-1:0]  ram_wdata, ram_rdata;

  i16p_front u_front (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_func             (in_func),
    .in_position         (in_position),
    .in_sample           (in_sample),
    .in_mode             (in_mode),
    .in_left_available   (in_left_available),
    .in_top_available    (in_top_available),
    .in_corner_available (in_corner_available),
    .q_head              (q_head),
    .q_pop               (q_pop)
  );

  i16p_ram #(
    .WIDTH (STORE_W),
    .DEPTH (STORE_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  i16p_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .q_head         (q_head),
    .q_pop          (q_pop),
    .ram_we         (ram_we),
    .ram_waddr      (ram_waddr),
    .ram_wdata      (ram_wdata),
    .ram_raddr      (ram_raddr),
    .ram_rdata      (ram_rdata),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_status     (out_status),
    .out_quad_index (out_quad_index),
    .out_pel0       (out_pel0),
    .out_pel1       (out_pel1),
    .out_pel2       (out_pel2),
    .out_pel3       (out_pel3),
    .out_last       (out_last)
  );

  // a status result stands alone
  a_status_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status != ST_OK) |-> out_last && (out_quad_index == '0))
    else $error("status result not a single final transaction");

  // quads of one block follow without gaps and in order
  a_quad_stream: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall && !out_last |=>
      out_valid && (out_quad_index == $past(out_quad_index) + QUAD_W'(1)))
    else $error("quad stream broken or out of order");

  // the back end never pops an empty queue
  a_pop_valid: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> q_head.valid)
    else $error("command queue popped while empty");

endmodule

`default_nettype wire
